// File: hw/rtl/hata_pkg.sv
// ----------------------------------------------------------------------------
// hata_pkg
// Types, widths and the arctangent table for the heading and turn angle unit.
// ----------------------------------------------------------------------------
package hata_pkg;

    localparam int COORD_BITS    = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int NORM_BITS     = 52;
    localparam int NORM_STEPS    = 6;
    localparam int CORDIC_STAGES = 31;
    localparam int XY_BITS       = NORM_BITS + 4;
    localparam int TURN_BITS     = 32;
    localparam int Z_BITS        = TURN_BITS + 2;
    localparam int QUART_BITS    = TURN_BITS - 1;
    localparam int ACC_BITS      = TURN_BITS + 1;
    localparam int PIPE_LAT      = 2 + NORM_STEPS + CORDIC_STAGES + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic        [ANGLE_BITS-1:0] orientation;
    } cmd_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] heading;
        logic [ANGLE_BITS-1:0] turn_angle;
    } result_t;

    // exact angles that bypass the CORDIC residue
    typedef enum logic [1:0] {
        SPC_NONE,
        SPC_FLAT,
        SPC_UPRIGHT,
        SPC_DIAG
    } spc_t;

    typedef struct packed {
        logic                  neg_x;
        logic                  neg_y;
        spc_t                  spc;
        logic [ANGLE_BITS-1:0] orientation;
    } side_t;

    typedef struct packed {
        logic [NORM_BITS-1:0] ax;
        logic [NORM_BITS-1:0] ay;
    } norm_t;

    typedef struct packed {
        logic signed [XY_BITS-1:0] x;
        logic signed [XY_BITS-1:0] y;
        logic signed [Z_BITS-1:0]  z;
    } cordic_t;

    localparam logic [TURN_BITS-1:0] ATAN_TURNS [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000
    };

endpackage

// File: hw/rtl/heading_and_turn_angle.sv
// ----------------------------------------------------------------------------
// heading_and_turn_angle
// Heading from origin to target by a pipelined vectoring CORDIC, and the
// shortest turn from the current orientation to that heading.
//
//   port     dir  word      strobe  notes
//   cmd      in   cmd_t     start   taken when start is high and busy is low
//   result   out  result_t  done    valid for one cycle, cannot be held off
//
// One word enters per cycle; busy stays low. Each result passes through
// 2 front stages, 6 normalizer cells, 31 CORDIC cells and 2 output
// stages. Reset clears only the valid chain.
// ----------------------------------------------------------------------------
module heading_and_turn_angle
    import hata_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    logic    n_valid [NORM_STEPS+1];
    side_t   n_side  [NORM_STEPS+1];
    norm_t   n_data  [NORM_STEPS+1];

    logic    c_valid [CORDIC_STAGES+1];
    side_t   c_side  [CORDIC_STAGES+1];
    cordic_t c_data  [CORDIC_STAGES+1];

    assign busy = 1'b0;

    hata_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .cmd_in    (cmd),
        .valid_out (n_valid[0]),
        .side_out  (n_side[0]),
        .data_out  (n_data[0])
    );

    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        hata_norm_cell #(
            .SHIFT (1 << (NORM_STEPS - 1 - k))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (n_valid[k]),
            .side_in   (n_side[k]),
            .data_in   (n_data[k]),
            .valid_out (n_valid[k+1]),
            .side_out  (n_side[k+1]),
            .data_out  (n_data[k+1])
        );
    end

    assign c_valid[0]  = n_valid[NORM_STEPS];
    assign c_side[0]   = n_side[NORM_STEPS];
    assign c_data[0].x = $signed({{(XY_BITS-NORM_BITS){1'b0}}, n_data[NORM_STEPS].ax});
    assign c_data[0].y = $signed({{(XY_BITS-NORM_BITS){1'b0}}, n_data[NORM_STEPS].ay});
    assign c_data[0].z = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        hata_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (c_valid[i]),
            .side_in   (c_side[i]),
            .data_in   (c_data[i]),
            .valid_out (c_valid[i+1]),
            .side_out  (c_side[i+1]),
            .data_out  (c_data[i+1])
        );
    end

    hata_angle_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (c_valid[CORDIC_STAGES]),
        .side_in  (c_side[CORDIC_STAGES]),
        .z_in     (c_data[CORDIC_STAGES].z),
        .done     (done),
        .result   (result)
    );

endmodule

// File: hw/rtl/hata_front.sv
// ----------------------------------------------------------------------------
// hata_front
// Coordinate differences, magnitudes, signs and exact-angle detection.
// ----------------------------------------------------------------------------
module hata_front
    import hata_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid_in,
    input  cmd_t  cmd_in,
    output logic  valid_out,
    output side_t side_out,
    output norm_t data_out
);

    logic                        vld_a_reg;
    logic signed [DIFF_BITS-1:0] dx_reg;
    logic signed [DIFF_BITS-1:0] dy_reg;
    logic [ANGLE_BITS-1:0]       ori_reg;
    logic signed [DIFF_BITS-1:0] dx_next;
    logic signed [DIFF_BITS-1:0] dy_next;

    logic                        vld_b_reg;
    side_t                       side_reg;
    norm_t                       data_reg;
    side_t                       side_next;
    norm_t                       data_next;
    logic [DIFF_BITS-1:0]        ax;
    logic [DIFF_BITS-1:0]        ay;

    assign dx_next = {cmd_in.target_x[COORD_BITS-1], cmd_in.target_x}
                   - {cmd_in.origin_x[COORD_BITS-1], cmd_in.origin_x};
    assign dy_next = {cmd_in.target_y[COORD_BITS-1], cmd_in.target_y}
                   - {cmd_in.origin_y[COORD_BITS-1], cmd_in.origin_y};

    assign ax = dx_reg[DIFF_BITS-1] ? DIFF_BITS'(-dx_reg) : DIFF_BITS'(dx_reg);
    assign ay = dy_reg[DIFF_BITS-1] ? DIFF_BITS'(-dy_reg) : DIFF_BITS'(dy_reg);

    always_comb
    begin
        side_next.neg_x       = dx_reg[DIFF_BITS-1];
        side_next.neg_y       = dy_reg[DIFF_BITS-1];
        side_next.orientation = ori_reg;
        priority if (ay == '0)
            side_next.spc = SPC_FLAT;
        else if (ax == '0)
            side_next.spc = SPC_UPRIGHT;
        else if (ax == ay)
            side_next.spc = SPC_DIAG;
        else
            side_next.spc = SPC_NONE;
        data_next.ax = {{(NORM_BITS-DIFF_BITS){1'b0}}, ax};
        data_next.ay = {{(NORM_BITS-DIFF_BITS){1'b0}}, ay};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= valid_in;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        ori_reg  <= cmd_in.orientation;
        side_reg <= side_next;
        data_reg <= data_next;
    end

    assign valid_out = vld_b_reg;
    assign side_out  = side_reg;
    assign data_out  = data_reg;

endmodule

// File: hw/rtl/hata_norm_cell.sv
// ----------------------------------------------------------------------------
// hata_norm_cell
// One normalizer step: shifts both magnitudes left by SHIFT if room remains.
// ----------------------------------------------------------------------------
module hata_norm_cell
    import hata_pkg::*;
#(
    parameter int SHIFT = 1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid_in,
    input  side_t side_in,
    input  norm_t data_in,
    output logic  valid_out,
    output side_t side_out,
    output norm_t data_out
);

    logic                 valid_reg;
    side_t                side_reg;
    norm_t                data_reg;
    norm_t                data_next;
    logic [NORM_BITS-1:0] both;

    assign both = data_in.ax | data_in.ay;

    always_comb
    begin
        data_next = data_in;
        if (both[NORM_BITS-1 -: SHIFT] == '0)
        begin
            data_next.ax = data_in.ax << SHIFT;
            data_next.ay = data_in.ay << SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_in;
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign data_out  = data_reg;

endmodule

// File: hw/rtl/hata_cordic_cell.sv
// ----------------------------------------------------------------------------
// hata_cordic_cell
// One vectoring CORDIC micro-rotation, index STAGE.
// ----------------------------------------------------------------------------
module hata_cordic_cell
    import hata_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    valid_in,
    input  side_t   side_in,
    input  cordic_t data_in,
    output logic    valid_out,
    output side_t   side_out,
    output cordic_t data_out
);

    logic                      valid_reg;
    side_t                     side_reg;
    cordic_t                   data_reg;
    cordic_t                   data_next;
    logic signed [XY_BITS-1:0] xs;
    logic signed [XY_BITS-1:0] ys;
    logic signed [Z_BITS-1:0]  step;

    assign xs   = data_in.x >>> STAGE;
    assign ys   = data_in.y >>> STAGE;
    assign step = $signed({{(Z_BITS-TURN_BITS){1'b0}}, ATAN_TURNS[STAGE]});

    always_comb
    begin
        if (!data_in.y[XY_BITS-1])
        begin
            data_next.x = data_in.x + ys;
            data_next.y = data_in.y - xs;
            data_next.z = data_in.z + step;
        end
        else
        begin
            data_next.x = data_in.x - ys;
            data_next.y = data_in.y + xs;
            data_next.z = data_in.z - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_in;
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign data_out  = data_reg;

endmodule

// File: hw/rtl/hata_angle_out.sv
// ----------------------------------------------------------------------------
// hata_angle_out
// Clamp, exact angles, quadrant restore, rounding, then the shortest turn.
// ----------------------------------------------------------------------------
module hata_angle_out
    import hata_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     valid_in,
    input  side_t                    side_in,
    input  logic signed [Z_BITS-1:0] z_in,
    output logic                     done,
    output result_t                  result
);

    localparam logic [QUART_BITS-1:0] QUARTER  = QUART_BITS'(1) << (QUART_BITS - 1);
    localparam logic [ACC_BITS-1:0]   HALF     = ACC_BITS'(1) << (TURN_BITS - 1);
    localparam logic [ACC_BITS-1:0]   FULL     = ACC_BITS'(1) << TURN_BITS;
    localparam logic [ACC_BITS-1:0]   RND      = ACC_BITS'(1) << (TURN_BITS - 1 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] HALF_ANG = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    logic [QUART_BITS-1:0] zq;
    logic [ACC_BITS-1:0]   zx;
    logic [ACC_BITS-1:0]   acc;
    logic [ACC_BITS-1:0]   acc_rnd;

    logic                  vld1_reg;
    logic [ANGLE_BITS-1:0] head_reg;
    logic [ANGLE_BITS-1:0] ori_reg;
    logic [ANGLE_BITS-1:0] head_next;

    logic                  done_reg;
    result_t               result_reg;
    result_t               result_next;
    logic [ANGLE_BITS-1:0] diff;

    always_comb
    begin
        if (z_in[Z_BITS-1])
            zq = '0;
        else if (z_in > $signed({{(Z_BITS-QUART_BITS){1'b0}}, QUARTER}))
            zq = QUARTER;
        else
            zq = z_in[QUART_BITS-1:0];
        unique case (side_in.spc)
            SPC_FLAT:    zx = '0;
            SPC_UPRIGHT: zx = {{(ACC_BITS-QUART_BITS){1'b0}}, QUARTER};
            SPC_DIAG:    zx = {{(ACC_BITS-QUART_BITS){1'b0}}, QUARTER >> 1};
            SPC_NONE:    zx = {{(ACC_BITS-QUART_BITS){1'b0}}, zq};
            default:     zx = '0;
        endcase
        if (side_in.neg_x)
            acc = side_in.neg_y ? (HALF + zx) : (HALF - zx);
        else if (side_in.neg_y)
            acc = {1'b0, TURN_BITS'(FULL - zx)};
        else
            acc = zx;
        acc_rnd   = acc + RND;
        head_next = acc_rnd[TURN_BITS-1 -: ANGLE_BITS];
    end

    always_comb
    begin
        diff                   = ori_reg - head_reg;
        result_next.heading    = head_reg;
        result_next.turn_angle = (diff > HALF_ANG) ? ANGLE_BITS'(-diff) : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= valid_in;
            done_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg   <= head_next;
        ori_reg    <= side_in.orientation;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hw/rtl/hata_checker.sv
// ----------------------------------------------------------------------------
// hata_checker
// Port-level checks for the heading and turn angle unit.
// ----------------------------------------------------------------------------
module hata_checker
    import hata_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input cmd_t    cmd,
    input logic    done,
    input result_t result
);

    localparam logic [ANGLE_BITS-1:0] HALF_ANG = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("result missing after accepted word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##PIPE_LAT !done)
        else $error("result without command");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.turn_angle <= HALF_ANG))
        else $error("turn beyond half a turn");

    a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
        (start && cmd.origin_x == cmd.target_x && cmd.origin_y == cmd.target_y)
        |-> ##PIPE_LAT (result.heading == '0))
        else $error("coincident points give nonzero heading");

endmodule

bind heading_and_turn_angle hata_checker u_hata_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

// File: tb/heading_and_turn_angle_chk.sv
// ----------------------------------------------------------------------------
// heading_and_turn_angle_chk
// Watches the command and result channels of the heading and turn angle unit.
// Every accepted command word is run through a bit-exact vectoring CORDIC
// model and queued. Each result word is compared field by field with the
// oldest queued prediction. The mismatch count and the number of outstanding
// predictions go back to the testbench top.
// ----------------------------------------------------------------------------
module heading_and_turn_angle_chk
    import hata_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  cmd_t    cmd,
    input  logic    done,
    input  result_t result,
    output int      errors,
    output int      pending
);

    localparam longint unsigned SCALE_FLOOR  = 64'd1 << 51;
    localparam longint unsigned QUARTER      = 64'd1 << 30;
    localparam longint unsigned HALF         = 64'd1 << 31;
    localparam longint unsigned FULL         = 64'd1 << 32;
    localparam int              STEPS        = 31;
    localparam longint unsigned ANG_MASK     = (64'd1 << ANGLE_BITS) - 1;
    localparam longint unsigned ANG_HALF     = 64'd1 << (ANGLE_BITS - 1);
    localparam longint unsigned ROUND_BIT    = 64'd1 << (31 - ANGLE_BITS);

    // atan(2^-i) in 2^32-per-turn units
    localparam logic [31:0] ARC_STEP [STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000
    };

    result_t heading_q [$];
    int      mismatch_cnt;

    assign errors = mismatch_cnt;

    function automatic result_t predict_heading(cmd_t w);
        longint          dx;
        longint          dy;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned q;
        longint unsigned acc;
        longint unsigned hd;
        longint unsigned diff;
        longint unsigned tn;
        int              i;
        result_t         r;

        dx = longint'($signed(w.target_x)) - longint'($signed(w.origin_x));
        dy = longint'($signed(w.target_y)) - longint'($signed(w.origin_y));
        ax = (dx < 0) ? longint'(-dx) : dx;
        ay = (dy < 0) ? longint'(-dy) : dy;

        if (ax == 0 && ay == 0)
        begin
            acc = 0;
        end
        else
        begin
            if (ay == 0)
                q = 0;
            else if (ax == 0)
                q = QUARTER;
            else if (ax == ay)
                q = QUARTER >> 1;
            else
            begin
                while (ax < SCALE_FLOOR && ay < SCALE_FLOOR)
                begin
                    ax = ax << 1;
                    ay = ay << 1;
                end
                x = ax;
                y = ay;
                z = 0;
                for (i = 0; i < STEPS; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + longint'(ARC_STEP[i]);
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - longint'(ARC_STEP[i]);
                    end
                end
                if (z < 0)
                    z = 0;
                if (z > longint'(QUARTER))
                    z = QUARTER;
                q = z;
            end

            if (dx >= 0 && dy >= 0)
                acc = q;
            else if (dx < 0 && dy >= 0)
                acc = HALF - q;
            else if (dx < 0)
                acc = HALF + q;
            else
                acc = (FULL - q) & (FULL - 1);
        end

        hd   = ((acc + ROUND_BIT) >> (32 - ANGLE_BITS)) & ANG_MASK;
        diff = (longint'(w.orientation) - hd) & ANG_MASK;
        tn   = (diff > ANG_HALF) ? (ANG_MASK + 1 - diff) : diff;

        r.heading    = hd[ANGLE_BITS-1:0];
        r.turn_angle = tn[ANGLE_BITS-1:0];
        return r;
    endfunction

    initial
    begin
        mismatch_cnt = 0;
        pending      = 0;
    end

    always @(posedge clk)
    begin
        result_t want;

        if (rst_n)
        begin
            if (done)
            begin
                if (heading_q.size() == 0)
                begin
                    $error("result word with no command outstanding: heading %0d turn %0d",
                           result.heading, result.turn_angle);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                else
                begin
                    want = heading_q.pop_front();
                    if (result.heading !== want.heading)
                    begin
                        $error("heading: expected %0d, got %0d", want.heading, result.heading);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                    if (result.turn_angle !== want.turn_angle)
                    begin
                        $error("turn_angle: expected %0d, got %0d",
                               want.turn_angle, result.turn_angle);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                end
            end
            if (start && !busy)
                heading_q.push_back(predict_heading(cmd));
            pending <= heading_q.size();
        end
    end

endmodule

// File: tb/heading_and_turn_angle_tb.sv
// ----------------------------------------------------------------------------
// heading_and_turn_angle_tb
// Stimulus for the heading and turn angle unit: a directed set of axis,
// diagonal, coincident, wrap and extreme-span vectors, then random command
// words of full-range, mid-span, near-coincident, axis and diagonal geometry,
// with random start gaps. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module heading_and_turn_angle_tb
    import hata_pkg::*;
();

    localparam int RANDOM_WORDS = 1600;
    localparam int CALM_TAIL    = 200;
    localparam int CYCLE_LIMIT  = 100000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;
    int      errors;
    int      pending;
    int      cycle_cnt;
    logic    gaps_on;
    logic    noisy_run;

    heading_and_turn_angle uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    heading_and_turn_angle_chk chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("heading_and_turn_angle: mismatch");
            $finish;
        end
    end

    function automatic cmd_t make_word(int ox, int oy, int tx, int ty, int o);
        cmd_t w;
        w.origin_x    = ox;
        w.origin_y    = oy;
        w.target_x    = tx;
        w.target_y    = ty;
        w.orientation = o[ANGLE_BITS-1:0];
        return w;
    endfunction

    function automatic int signed_pick(int mag);
        return $urandom_range(1) ? mag : -mag;
    endfunction

    function automatic cmd_t random_word();
        int   kind;
        int   ox;
        int   oy;
        int   dx;
        int   dy;
        int   o;
        cmd_t w;

        kind = $urandom_range(9);
        ox   = $urandom;
        oy   = $urandom;
        case ($urandom_range(7))
            0:       o = 0;
            1:       o = 16'hFFFF;
            2:       o = 16'h8000;
            default: o = $urandom_range(16'hFFFF);
        endcase
        case (kind)
            4, 5:
            begin
                dx = int'($urandom_range(64)) - 32;
                dy = int'($urandom_range(64)) - 32;
            end
            6:
            begin
                ox = ox >>> 2;
                oy = oy >>> 2;
                if ($urandom_range(1))
                begin
                    dx = signed_pick($urandom_range(1 << 28, 1));
                    dy = 0;
                end
                else
                begin
                    dx = 0;
                    dy = signed_pick($urandom_range(1 << 28, 1));
                end
            end
            7:
            begin
                ox = ox >>> 2;
                oy = oy >>> 2;
                dx = $urandom_range(1 << 28, 1);
                dy = signed_pick(dx);
                dx = signed_pick(dx);
            end
            8:
            begin
                dx = 0;
                dy = 0;
            end
            9:
            begin
                dx = int'($urandom_range(1 << 20)) - (1 << 19);
                dy = int'($urandom_range(1 << 20)) - (1 << 19);
            end
            default:
            begin
                w = make_word(ox, oy, $urandom, $urandom, o);
                return w;
            end
        endcase
        w = make_word(ox, oy, ox + dx, oy + dy, o);
        return w;
    endfunction

    task automatic issue(cmd_t w);
        int gap;
        if (gaps_on && noisy_run && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(3, 1);
            start <= 1'b0;
            cmd   <= random_word();
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    initial
    begin
        int n;

        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        gaps_on   = 1'b1;
        noisy_run = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: coincident, axes, diagonals, extremes, wrap, half turn
        issue(make_word(0, 0, 0, 0, 0));
        issue(make_word(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF));
        issue(make_word(0, 0, 32'h10000, 0, 0));
        issue(make_word(0, 0, 0, 32'h10000, 16'h4000));
        issue(make_word(0, 0, -32'sh10000, 0, 16'h8000));
        issue(make_word(0, 0, 0, -32'sh10000, 16'hC000));
        issue(make_word(0, 0, 5, 5, 16'h1234));
        issue(make_word(0, 0, -7, 7, 0));
        issue(make_word(1, 1, -99, -99, 16'hFFFF));
        issue(make_word(0, 0, 32'h7FFFFFFF, 32'h80000001, 0));
        issue(make_word(32'h80000000, 0, 32'h7FFFFFFF, 1, 16'h7FFF));
        issue(make_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 16'h8001));
        issue(make_word(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000));
        issue(make_word(0, 0, 32'h7FFFFFFF, -1, 0));
        issue(make_word(0, 0, 1, 0, 16'h8000));
        issue(make_word(0, 0, -1, 0, 0));
        issue(make_word(0, 0, 1, 2, 16'h7FFF));
        issue(make_word(0, 0, 2, -1, 16'h8001));
        issue(make_word(0, 0, -3, 1, 16'hFFFF));
        issue(make_word(0, 0, -1, -3, 16'h0001));
        issue(make_word(0, 0, 32'h7FFFFFFF, 1, 0));
        issue(make_word(0, 0, 1, 32'h7FFFFFFF, 0));
        issue(make_word(-5, -5, -5, -6, 16'h3FFF));
        issue(make_word(12345678, -9876543, -55555, 4444444, 16'hA5A5));

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 50 == 0)
                noisy_run = ($urandom_range(2) != 0);
            if (n == RANDOM_WORDS - CALM_TAIL)
                gaps_on = 1'b0;
            issue(random_word());
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("heading_and_turn_angle: match");
        else
            $display("heading_and_turn_angle: mismatch");
        $finish;
    end

endmodule

// File: heading_and_turn_angle.f
hw/rtl/hata_pkg.sv
hw/rtl/hata_front.sv
hw/rtl/hata_norm_cell.sv
hw/rtl/hata_cordic_cell.sv
hw/rtl/hata_angle_out.sv
hw/rtl/heading_and_turn_angle.sv
hw/rtl/hata_checker.sv
tb/heading_and_turn_angle_chk.sv
tb/heading_and_turn_angle_tb.sv
